// File: src/rig_pkg.sv
// rig_pkg: shared constants, types and the character table for the identifier generator
// no dependencies; compiled first
package rig_pkg;

	// identifier length default and fixed field widths
	localparam int ID_LENGTH_DEF = 16;
	localparam int TICK_W        = 24;
	localparam int CHAR_W        = 7;
	localparam int HASH_W        = 64;
	localparam int GEN_W         = 32;
	localparam int PREFIX_CHARS  = 4;

	// linear congruential generator constants
	localparam logic [GEN_W-1:0] LCG_MUL = 32'd214013;
	localparam logic [GEN_W-1:0] LCG_INC = 32'd2531011;

	// generator control from the sequencer and the seed port
	typedef struct packed {
		logic load;
		logic step;
	} lcg_ctl_t;

	// 64-entry character table: 0-9, a-z, A-Z, then a and b
	function automatic logic [CHAR_W-1:0] char_of(input logic [5:0] idx);
		logic [CHAR_W-1:0] code;
		if (idx < 6'd10) begin
			code = 7'h30 + {1'b0, idx};
		end else if (idx < 6'd36) begin
			code = 7'h61 + {1'b0, idx - 6'd10};
		end else if (idx < 6'd62) begin
			code = 7'h41 + {1'b0, idx - 6'd36};
		end else begin
			code = 7'h61 + {1'b0, idx - 6'd62};
		end
		return code;
	endfunction

endpackage

// File: src/rig_if.sv
// rig_if: valid/ready channel interfaces for requests and characters
// depends on rig_pkg for field widths

interface rig_req_if;
	logic                         valid;
	logic                         ready;
	logic [rig_pkg::TICK_W-1:0]   tick_count;

	modport source (output valid, output tick_count, input ready);
	modport sink   (input valid, input tick_count, output ready);
endinterface

interface rig_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rig_pkg::CHAR_W-1:0]   character;
	logic                         last_char;
	logic [rig_pkg::HASH_W-1:0]   id_hash;

	modport source (output valid, output character, output last_char, output id_hash,
		input ready);
	modport sink   (input valid, input character, input last_char, input id_hash,
		output ready);
endinterface

// File: src/rig_lcg.sv
// rig_lcg: generator state register and its shared multiply-add step unit
// depends on rig_pkg
module rig_lcg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rig_pkg::lcg_ctl_t           ctl,
	input  logic [rig_pkg::GEN_W-1:0]   load_value,
	output logic [rig_pkg::GEN_W-1:0]   state
);
	import rig_pkg::*;

	logic [GEN_W-1:0] gen_q;
	logic [GEN_W-1:0] gen_next;

	// one step: g * 214013 + 2531011, wrapping at 32 bits
	assign gen_next = gen_q * LCG_MUL + LCG_INC;

	// seed load takes priority; step only while a transaction runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (ctl.load) begin
			gen_q <= load_value;
		end else if (ctl.step) begin
			gen_q <= gen_next;
		end
	end

	assign state = gen_q;

endmodule

// File: src/rig_seq.sv
// rig_seq: sequencer that emits the identifier characters and folds the hash
// depends on rig_pkg and the channel interfaces in rig_if
module rig_seq #(
	parameter int ID_LENGTH = rig_pkg::ID_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rig_req_if.sink                     req,
	rig_rsp_if.source                   rsp,
	input  logic [rig_pkg::GEN_W-1:0]   gen,
	output logic                        gen_step
);
	import rig_pkg::*;

	localparam int K_W = $clog2(ID_LENGTH);
	localparam logic [K_W-1:0] K_LAST   = K_W'(ID_LENGTH - 1);
	localparam logic [K_W-1:0] K_PREFIX = K_W'(PREFIX_CHARS - 1);

	typedef enum logic [1:0] {S_IDLE, S_EMIT, S_STEP} state_t;

	state_t              state_q;
	logic [K_W-1:0]      k_q;
	logic                half_q;
	logic [TICK_W-1:0]   tick_q;
	logic [HASH_W-1:0]   hash_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic [HASH_W-1:0]   out_hash_q;

	logic                can_emit;
	logic                emit;
	logic                is_last;
	logic [5:0]          idx;
	logic [CHAR_W-1:0]   code;
	logic [HASH_W-1:0]   hash_next;

	// output slot free or being drained this cycle
	assign can_emit = !out_valid_q || rsp.ready;
	assign emit     = (state_q == S_EMIT) && can_emit;
	assign is_last  = (k_q == K_LAST);

	// table index: tick slices first, then generator slices
	always_comb begin
		if (k_q <= K_PREFIX) begin
			case (k_q[1:0])
				2'd0:    idx = tick_q[5:0];
				2'd1:    idx = tick_q[11:6];
				2'd2:    idx = tick_q[17:12];
				default: idx = tick_q[23:18];
			endcase
		end else begin
			idx = half_q ? gen[27:22] : gen[21:16];
		end
	end

	assign code      = char_of(idx);
	// h*31 + c as a shift and subtract
	assign hash_next = (hash_q << 5) - hash_q + {{(HASH_W-CHAR_W){1'b0}}, code};

	assign req.ready = (state_q == S_IDLE);
	assign gen_step  = (state_q == S_STEP);

	// sequencer, hash accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			half_q      <= 1'b0;
			tick_q      <= '0;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
			out_hash_q  <= '0;
		end else begin
			// output valid: set on a new character, cleared once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						tick_q  <= req.tick_count;
						hash_q  <= '0;
						k_q     <= '0;
						half_q  <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						char_q      <= code;
						last_q      <= is_last;
						out_hash_q  <= is_last ? hash_next : '0;
						hash_q      <= hash_next;
						k_q         <= k_q + K_W'(1);
						if (is_last) begin
							state_q <= S_IDLE;
						end else if (k_q == K_PREFIX) begin
							state_q <= S_STEP;
						end else if (k_q > K_PREFIX) begin
							// second character of a pair, or fetch the next step
							if (!half_q) begin
								half_q <= 1'b1;
							end else begin
								half_q  <= 1'b0;
								state_q <= S_STEP;
							end
						end
					end
				end
				S_STEP: begin
					state_q <= S_EMIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.character = char_q;
	assign rsp.last_char = last_q;
	assign rsp.id_hash   = out_hash_q;

endmodule

// File: src/random_id_generator_with_hash_unit.sv
// random identifier generator with polynomial hash: one request, ID_LENGTH characters
// an accepted request moves the sequencer to emit, which registers the first character
// a new request is taken only after the last character of the one before; emits wait
// while the output slot is full; generator steps use the shared multiply-add in rig_lcg
// reset: generator state cleared to zero, sequencer idle, no character pending
// depends on rig_pkg, rig_if, rig_lcg and rig_seq
module random_id_generator_with_hash_unit #(
	parameter int ID_LENGTH = rig_pkg::ID_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_we,
	input  logic [rig_pkg::GEN_W-1:0]   seed_wdata,
	rig_req_if.sink                     req,
	rig_rsp_if.source                   rsp
);
	import rig_pkg::*;

	logic             gen_step;
	logic [GEN_W-1:0] gen;
	lcg_ctl_t         lcg_ctl;

	// seed write reloads the generator state
	assign lcg_ctl.load = seed_we;
	assign lcg_ctl.step = gen_step;

	rig_lcg u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (lcg_ctl),
		.load_value (seed_wdata),
		.state      (gen)
	);

	rig_seq #(
		.ID_LENGTH (ID_LENGTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.gen      (gen),
		.gen_step (gen_step)
	);

endmodule
